// ----- sv/psc_pkg.sv -----
`default_nettype none
package psc_pkg;

	// stack depth and field widths
	localparam int MAX_PLANES = 64;
	localparam int CNT_W      = $clog2(MAX_PLANES + 1);
	localparam int SMP_W      = 16;
	localparam int WGT_W      = 16;
	localparam int FRAC_W     = 12;
	localparam int PROD_W     = SMP_W + WGT_W;
	localparam int VAL_W      = 20;
	localparam int SUM_W      = 26;
	localparam int MODE_W     = 3;
	localparam int STEP_W     = $clog2(SUM_W + 1);

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef enum logic [MODE_W-1:0] {
		MODE_SUM    = 3'd0,
		MODE_MEAN   = 3'd1,
		MODE_MEDIAN = 3'd2,
		MODE_MIN    = 3'd3,
		MODE_MAX    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_RUN    = 2'd0,
		ST_LOAD   = 2'd1,
		ST_FINISH = 2'd2
	} state_t;

	// shared control broadcast along the cell chain
	typedef struct packed {
		logic             ins;
		logic             shl;
		logic [VAL_W-1:0] v;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ----- sv/pixel_stack_combiner.sv -----
`default_nettype none
// Combines one pixel position across a stack of up to MAX_PLANES planes. Each beat on the
// input carries a sample and its Q4.12 plane weight; the weighted value (sample * weight)
// >> 12 is registered, then folded into a running sum, minimum and maximum and slotted into
// a chain of insertion cells that keeps the column sorted for the median. Within a column
// one beat is taken every cycle. The beat marked last_plane closes the column: the block
// then stalls its input while the 26-step restoring divider for the mean runs alongside
// the n/2 shifts of the cell chain (n = kept planes) that bring the median to cell 0,
// and further while the previous result still waits to be taken.
// The result then sits in an output register, so the next column
// streams in while it waits to be taken. Samples beyond MAX_PLANES are dropped and flagged
// in overflow. mode (0 sum, 1 mean, 2 median, 3 min, 4 max, others give zero) is sampled at
// the end of the column and must only be written while the block is idle.
module pixel_stack_combiner (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// configuration
	input  wire logic                       mode_we,
	input  wire logic [psc_pkg::MODE_W-1:0] mode_wdata,
	// sample channel
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [psc_pkg::SMP_W-1:0]  sample,
	input  wire logic [psc_pkg::WGT_W-1:0]  plane_weight,
	input  wire logic                       last_plane,
	// result channel
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [psc_pkg::SUM_W-1:0]       combined,
	output logic                            overflow
);

	localparam int N = psc_pkg::MAX_PLANES;

	psc_pkg::mode_t             mode_q;
	psc_pkg::state_t            st_q, st_d;

	// weighting stage
	logic [psc_pkg::PROD_W-1:0] prod;
	logic                       s1_valid_q;
	logic                       s1_last_q;
	logic [psc_pkg::VAL_W-1:0]  s1_val_q;

	// column state
	logic [psc_pkg::CNT_W-1:0]  count_q;
	logic [psc_pkg::SUM_W-1:0]  sum_q;
	logic [psc_pkg::VAL_W-1:0]  min_q;
	logic [psc_pkg::VAL_W-1:0]  max_q;
	logic                       drop_q;
	logic [psc_pkg::CNT_W-1:0]  med_q;
	logic [psc_pkg::SUM_W:0]    sum_ext;

	// output register
	logic                       out_valid_q;
	logic [psc_pkg::SUM_W-1:0]  combined_q;
	logic                       overflow_q;

	// control decode
	logic                       in_acc;
	logic                       take;
	logic                       keep;
	logic                       div_start;
	logic                       fin_ready;
	logic                       emit;
	logic [psc_pkg::SUM_W-1:0]  result;
	logic [psc_pkg::SUM_W-1:0]  quotient;
	logic                       div_done;

	psc_pkg::cell_ctl_t         ctl;
	logic [psc_pkg::VAL_W-1:0]  cell_val [N];
	logic                       cell_gt  [N];

	// input is held off while a column is being closed
	assign in_stall = (st_q != psc_pkg::ST_RUN) || (s1_valid_q && s1_last_q);
	assign in_acc   = in_valid && !in_stall;
	assign prod     = psc_pkg::PROD_W'(sample) * psc_pkg::PROD_W'(plane_weight);

	assign take      = (st_q == psc_pkg::ST_RUN) && s1_valid_q;
	assign keep      = take && (count_q < psc_pkg::CNT_W'(N));
	assign div_start = (st_q == psc_pkg::ST_LOAD);
	assign fin_ready = (med_q == '0) && div_done && (!out_valid_q || !out_stall);
	assign emit      = (st_q == psc_pkg::ST_FINISH) && fin_ready;
	assign sum_ext   = {1'b0, sum_q} + (psc_pkg::SUM_W + 1)'(s1_val_q);

	assign ctl.ins = keep;
	assign ctl.shl = (st_q == psc_pkg::ST_FINISH) && (med_q != '0);
	assign ctl.v   = s1_val_q;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= psc_pkg::MODE_MEAN;
		end else if (mode_we) begin
			mode_q <= psc_pkg::mode_t'(mode_wdata);
		end
	end

	// weighting stage: product registered before the cell chain sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_last_q  <= 1'b0;
		end else begin
			s1_valid_q <= in_acc;
			if (in_acc) begin
				s1_last_q <= last_plane;
			end else if (take) begin
				s1_last_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_val_q <= prod[psc_pkg::FRAC_W +: psc_pkg::VAL_W];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= psc_pkg::ST_RUN;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			psc_pkg::ST_RUN: begin
				if (take && s1_last_q) begin
					st_d = psc_pkg::ST_LOAD;
				end
			end
			psc_pkg::ST_LOAD: begin
				st_d = psc_pkg::ST_FINISH;
			end
			psc_pkg::ST_FINISH: begin
				if (fin_ready) begin
					st_d = psc_pkg::ST_RUN;
				end
			end
			default: begin
				st_d = psc_pkg::ST_RUN;
			end
		endcase
	end

	// running statistics of the open column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			min_q   <= '1;
			max_q   <= '0;
			drop_q  <= 1'b0;
		end else if (emit) begin
			count_q <= '0;
			sum_q   <= '0;
			min_q   <= '1;
			max_q   <= '0;
			drop_q  <= 1'b0;
		end else if (keep) begin
			count_q <= count_q + 1'b1;
			sum_q   <= sum_ext[psc_pkg::SUM_W] ? psc_pkg::SUM_MAX
				: sum_ext[psc_pkg::SUM_W-1:0];
			if (s1_val_q < min_q) begin
				min_q <= s1_val_q;
			end
			if (s1_val_q > max_q) begin
				max_q <= s1_val_q;
			end
		end else if (take) begin
			drop_q <= 1'b1;
		end
	end

	// shifts left to walk the median down to cell 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			med_q <= '0;
		end else if (div_start) begin
			med_q <= count_q >> 1;
		end else if (ctl.shl) begin
			med_q <= med_q - 1'b1;
		end
	end

	psc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.quotient (quotient),
		.done     (div_done)
	);

	// sorted insertion chain, ascending from cell 0
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic                      prev_gt;
		logic [psc_pkg::VAL_W-1:0] prev_val;
		logic [psc_pkg::VAL_W-1:0] next_val;

		if (i == 0) begin : g_head
			assign prev_gt  = 1'b0;
			assign prev_val = '0;
		end else begin : g_body
			assign prev_gt  = cell_gt[i-1];
			assign prev_val = cell_val[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign next_val = cell_val[i];
		end else begin : g_link
			assign next_val = cell_val[i+1];
		end

		psc_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occ      (count_q > psc_pkg::CNT_W'(i)),
			.prev_gt  (prev_gt),
			.prev_val (prev_val),
			.next_val (next_val),
			.val      (cell_val[i]),
			.gt       (cell_gt[i])
		);
	end

	// result select
	always_comb begin
		unique case (mode_q)
			psc_pkg::MODE_SUM:    result = sum_q;
			psc_pkg::MODE_MEAN:   result = quotient;
			psc_pkg::MODE_MEDIAN: result = psc_pkg::SUM_W'(cell_val[0]);
			psc_pkg::MODE_MIN:    result = psc_pkg::SUM_W'(min_q);
			psc_pkg::MODE_MAX:    result = psc_pkg::SUM_W'(max_q);
			default:              result = '0;
		endcase
	end

	// output register, one beat per column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			combined_q <= result;
			overflow_q <= drop_q;
		end
	end

	assign out_valid = out_valid_q;
	assign combined  = combined_q;
	assign overflow  = overflow_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= psc_pkg::CNT_W'(N))
		else $error("plane count beyond stack depth");

	a_close_column: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == psc_pkg::ST_RUN && s1_valid_q && s1_last_q) |=> st_q == psc_pkg::ST_LOAD)
		else $error("last beat did not close the column");

	a_chain_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == psc_pkg::ST_RUN && count_q >= psc_pkg::CNT_W'(2)) |-> cell_val[0] <= cell_val[1])
		else $error("insertion chain out of order");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> min_q <= max_q)
		else $error("running minimum above maximum");

	a_no_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> div_done && $past(st_q) != psc_pkg::ST_RUN)
		else $error("result emitted before the column was closed");

endmodule
`default_nettype wire

// ----- sv/psc_cell.sv -----
`default_nettype none
module psc_cell (
	input  wire logic                      clk,
	input  wire psc_pkg::cell_ctl_t        ctl,
	input  wire logic                      occ,
	input  wire logic                      prev_gt,
	input  wire logic [psc_pkg::VAL_W-1:0] prev_val,
	input  wire logic [psc_pkg::VAL_W-1:0] next_val,
	output logic [psc_pkg::VAL_W-1:0]      val,
	output logic                           gt
);

	logic [psc_pkg::VAL_W-1:0] val_q;

	// an empty cell behaves as larger than any value
	assign gt  = !occ || (val_q > ctl.v);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt) begin
				val_q <= ctl.v;
			end
		end else if (ctl.shl) begin
			val_q <= next_val;
		end
	end

endmodule
`default_nettype wire

// ----- sv/psc_div.sv -----
`default_nettype none
module psc_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [psc_pkg::SUM_W-1:0] dividend,
	input  wire logic [psc_pkg::CNT_W-1:0] divisor,
	output logic [psc_pkg::SUM_W-1:0]      quotient,
	output logic                           done
);

	logic [psc_pkg::STEP_W-1:0] steps_q;
	logic [psc_pkg::SUM_W-1:0]  quo_q;
	logic [psc_pkg::CNT_W-1:0]  rem_q;
	logic [psc_pkg::CNT_W:0]    trial;
	logic [psc_pkg::CNT_W:0]    diff;
	logic                       fits;

	// restoring divide, one quotient bit per cycle
	assign trial = {rem_q, quo_q[psc_pkg::SUM_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (start) begin
			steps_q <= psc_pkg::STEP_W'(psc_pkg::SUM_W);
		end else if (steps_q != '0) begin
			steps_q <= steps_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (steps_q != '0) begin
			quo_q <= {quo_q[psc_pkg::SUM_W-2:0], fits};
			rem_q <= fits ? diff[psc_pkg::CNT_W-1:0] : trial[psc_pkg::CNT_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = (steps_q == '0);

endmodule
`default_nettype wire
